### hw/rtl/kmce_pkg.sv
// Package: shared types and constants for the key matrix change event block.
package kmce_pkg;

	localparam int ROWS = 8;
	localparam int COLS = 16;
	localparam int QDEPTH = 2;

	localparam int RowIdxW = (ROWS > 8) ? 3 : ((ROWS > 1) ? $clog2(ROWS) : 1);
	localparam int QPtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCntW = $clog2(QDEPTH + 1);

	localparam logic [15:0] COL_MASK =
		(COLS >= 16) ? 16'hFFFF : 16'((32'd1 << COLS) - 32'd1);

	typedef enum logic [1:0] {
		ACT_SCAN  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  row_index;
		logic [15:0] row_bits;
		logic [31:0] timestamp;
		logic [4:0]  active_layer;
		logic [7:0]  modifiers;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_row;
		logic [3:0]  event_col;
		logic        pressed;
		logic [31:0] event_time;
		logic [4:0]  event_layer;
		logic [7:0]  event_mods;
		logic        last;
	} result_t;

	// One row's worth of work: the columns that changed and the new row bits.
	typedef struct packed {
		logic [2:0]  row;
		logic [15:0] changed;
		logic [15:0] bits;
		logic [31:0] ts;
		logic [4:0]  layer;
		logic [7:0]  mods;
	} job_t;

	// Queue status seen by either side.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### hw/rtl/kmce_front.sv
// Front end: takes input words, tracks row state and queues rows that changed.
module kmce_front import kmce_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	input  q_stat_t q_stat,
	output logic    full,
	output logic    job_push,
	output job_t    job
);

	logic [15:0]        prev_rows_q [ROWS];
	logic [ROWS-1:0]    row_seen_q;
	logic               capturing_q;

	logic               accept;
	logic               row_ok;
	logic [RowIdxW-1:0] ridx;
	logic [15:0]        bits;
	logic [15:0]        changed;
	logic               scan_live;

	assign full    = q_stat.full;
	assign accept  = push && !full;
	assign row_ok  = int'(item.row_index) < ROWS;
	assign ridx    = item.row_index[RowIdxW-1:0];
	assign bits    = item.row_bits & COL_MASK;
	assign changed = bits ^ prev_rows_q[ridx];

	assign scan_live = accept && (item.action == ACT_SCAN) && capturing_q && row_ok;
	assign job_push  = scan_live && row_seen_q[ridx] && (changed != 16'd0);

	always_comb begin
		job.row     = item.row_index;
		job.changed = changed;
		job.bits    = bits;
		job.ts      = item.timestamp;
		job.layer   = item.active_layer;
		job.mods    = item.modifiers;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_seen_q  <= '0;
			capturing_q <= 1'b0;
			for (int i = 0; i < ROWS; i++) begin
				prev_rows_q[i] <= '0;
			end
		end else if (accept) begin
			case (item.action)
				ACT_SCAN: begin
					if (capturing_q && row_ok) begin
						prev_rows_q[ridx] <= bits;
						row_seen_q[ridx]  <= 1'b1;
					end
				end
				ACT_START: begin
					row_seen_q  <= '0;
					capturing_q <= 1'b1;
				end
				ACT_STOP: begin
					capturing_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hw/rtl/kmce_queue.sv
// Short job queue between the front and back ends.
module kmce_queue import kmce_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  job_t    wr_job,
	input  logic    rd_en,
	output job_t    rd_job,
	output q_stat_t stat
);

	job_t             slot_q [QDEPTH];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign stat.full  = (count_q == QCntW'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_job     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/kmce_back.sv
// Back end: walks a job's changed columns, one event word per cycle while the receiver takes them.
module kmce_back import kmce_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  job_t    q_job,
	output logic    q_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	job_t        job_q;
	logic [15:0] mask_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        can_load;
	logic        emit;
	logic [3:0]  col;
	logic [15:0] rest;

	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign can_load = !out_valid_q || pop;
	assign emit     = (mask_q != 16'd0) && can_load;
	assign q_pop    = (mask_q == 16'd0) && !q_stat.empty;
	assign rest     = mask_q & (mask_q - 16'd1);

	// lowest set column
	always_comb begin
		col = '0;
		for (int i = 15; i >= 0; i--) begin
			if (mask_q[i]) begin
				col = 4'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			out_q.event_row   <= job_q.row;
			out_q.event_col   <= col;
			out_q.pressed     <= job_q.bits[col];
			out_q.event_time  <= job_q.ts;
			out_q.event_layer <= job_q.layer;
			out_q.event_mods  <= job_q.mods;
			out_q.last        <= (rest == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mask_q <= q_job.changed;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/key_matrix_change_events.sv
// Top level: key matrix change detector with queue-style input and result ports.
//
// Input side: drive item and raise push; a word is taken at a rising edge with
// push high and full low. Each word is a row scan, a start capture or a stop
// capture command. Commands and scans that cause no events are not queued.
// Result side: while empty is low, result holds the oldest event word; raise
// pop to take it. Events of one row come lowest column first; the final one
// of that row carries last.
// A changed row's job is written into the queue on accept, then loaded into
// the back end, and its first event then goes to the output register. The
// back end walks the changed columns one event per cycle while the receiver
// takes them, and loads the next job once the row is done.
// A two-deep job queue parts the front from the back: the front keeps taking
// words until the queue fills, and full reflects a full queue only.
// When the receiver stalls, the output register holds its word and the back
// end waits; the queue then fills and full rises.
// Reset clears all stored rows, row valid marks and the capture flag, and
// leaves the queue and output register empty.
module key_matrix_change_events import kmce_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	q_stat_t q_stat;
	logic    job_push;
	job_t    job_in;
	job_t    job_out;
	logic    job_pop;

	// Row state and classification of incoming words.
	kmce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.q_stat   (q_stat),
		.full     (full),
		.job_push (job_push),
		.job      (job_in)
	);

	// Decoupling queue for rows with changed columns.
	kmce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.rd_en  (job_pop),
		.rd_job (job_out),
		.stat   (q_stat)
	);

	// Event generation and output register.
	kmce_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_job  (job_out),
		.q_pop  (job_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

### tb/sv/tb_key_matrix_change_events.sv
// Self-checking testbench for the key matrix change event block: queue-fed driver, monitor, predictor.
module tb_key_matrix_change_events;
	import kmce_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Run length guard. The slowest correct run is roughly 410 words, each
	// causing 16 events that each wait out the longest receiver stall, plus
	// the longest sender gap and the column walk.
	localparam int unsigned LIMIT = 1500000;
	// Quiet time after the last expected event, well past the column walk.
	localparam int SETTLE_CYCLES = 40;
	// Number of useful random words (ignored words are not counted).
	localparam int RANDOM_WORDS = 340;
	// Columns the block actually compares; bits above COLS are dropped.
	localparam logic [15:0] KEEP_COLS =
		(COLS >= 16) ? 16'hFFFF : 16'((32'd1 << COLS) - 32'd1);

	// One queued input word; settle makes the driver hold it back until
	// every expected event has drained.
	typedef struct {
		item_t word;
		bit    settle;
	} feed_t;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	key_matrix_change_events dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	feed_t   feed_q[$];
	result_t due_events[$];

	// Predictor state: stored row copies, per-row valid marks, capture flag.
	logic [15:0]     seen_bits [ROWS];
	logic [ROWS-1:0] row_valid;
	logic            capture_on;

	// Generator shadow, only used to shape well-formed scan sequences.
	logic [15:0] gen_rows [8];
	bit          gen_capture;

	int          errors;
	int unsigned cycles;
	int unsigned words_sent;
	int unsigned events_seen;
	int unsigned presses_seen;
	int unsigned starts_sent;
	int unsigned stops_sent;
	int unsigned ignored_sent;
	int          hold_left;
	int          pop_hold;
	int          calm_left;

	// Gap length: mostly none, sometimes a few cycles, rarely a long stretch.
	// During a calm window there are no gaps at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left > 0 || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Works out the events one accepted word causes and queues them.
	function automatic void predict_row_events(input item_t w);
		logic [15:0] cur;
		logic [15:0] diff;
		result_t     ev;
		int          ri;
		ri = int'(w.row_index);
		case (action_t'(w.action))
			ACT_START: begin
				row_valid = '0;
				capture_on = 1'b1;
			end
			ACT_STOP: begin
				capture_on = 1'b0;
			end
			ACT_SCAN: begin
				if (capture_on && ri < ROWS) begin
					cur = w.row_bits & KEEP_COLS;
					if (!row_valid[ri]) begin
						// first scan since start only primes the copy
						seen_bits[ri] = cur;
						row_valid[ri] = 1'b1;
					end else begin
						diff = cur ^ seen_bits[ri];
						for (int c = 0; c < 16; c++) begin
							if (diff[c]) begin
								diff[c] = 1'b0;
								ev.event_row = w.row_index;
								ev.event_col = 4'(c);
								ev.pressed = cur[c];
								ev.event_time = w.timestamp;
								ev.event_layer = w.active_layer;
								ev.event_mods = w.modifiers;
								ev.last = (diff == '0);
								due_events.push_back(ev);
							end
						end
						seen_bits[ri] = cur;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic queue_word(input action_t act, input int row, input logic [15:0] bits,
			input logic [31:0] ts, input logic [4:0] layer, input logic [7:0] mods,
			input bit settle);
		feed_t f;
		f.word.action = act;
		f.word.row_index = 3'(row);
		f.word.row_bits = bits;
		f.word.timestamp = ts;
		f.word.active_layer = layer;
		f.word.modifiers = mods;
		f.settle = settle;
		feed_q.push_back(f);
	endtask

	task automatic queue_random(input action_t act, input int row, input logic [15:0] bits,
			input bit settle);
		queue_word(act, row, bits, $urandom, 5'($urandom_range(0, 31)), 8'($urandom), settle);
	endtask

	// Next scan of a row: mostly a few keys change, sometimes none, sometimes
	// a random row or the full complement.
	function automatic logic [15:0] next_row(input logic [15:0] old);
		logic [15:0] v;
		int          r;
		int          n;
		v = old;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			n = $urandom_range(1, 3);
			for (int k = 0; k < n; k++)
				v[$urandom_range(0, 15)] ^= 1'b1;
		end else if (r < 70) begin
			v = old;
		end else if (r < 88) begin
			v = 16'($urandom);
		end else begin
			v = ~old;
		end
		return v;
	endfunction

	// Field compare against the expected event.
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// ---------------------------------------------------------------
	// Driver: changes inputs at the falling edge. A word stays on the
	// port until accepted; a gap is only opened after an accept.
	// ---------------------------------------------------------------
	always @(negedge clk) begin : drive
		logic go;
		go = 1'b0;
		if (arst_n) begin
			// now and then a calm window with no gaps on either side
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 249) == 0)
				calm_left = $urandom_range(30, 80);
			if (hold_left > 0)
				hold_left--;
			else if (feed_q.size() > 0 && (!feed_q[0].settle || due_events.size() == 0))
				go = 1'b1;
			push <= go;
			if (go)
				item <= feed_q[0].word;
			// receiver side
			if (pop_hold > 0) begin
				pop_hold--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Input accept: a word is taken when push is high and full is low at
	// the rising edge; the predictor runs on it right there.
	always @(posedge clk) begin : take
		if (arst_n && push && !full) begin
			predict_row_events(item);
			feed_q.pop_front();
			words_sent++;
			hold_left = pick_gap();
		end
	end

	// Monitor: an event word moves when pop is high and empty is low.
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n && pop && !empty) begin
			if (due_events.size() == 0) begin
				errors++;
				$display("%0t: event with none expected: actual %p", $time, result);
			end else begin
				want = due_events.pop_front();
				check_field("event_row", 32'(want.event_row), 32'(result.event_row));
				check_field("event_col", 32'(want.event_col), 32'(result.event_col));
				check_field("pressed", 32'(want.pressed), 32'(result.pressed));
				check_field("event_time", want.event_time, result.event_time);
				check_field("event_layer", 32'(want.event_layer), 32'(result.event_layer));
				check_field("event_mods", 32'(want.event_mods), 32'(result.event_mods));
				check_field("last", 32'(want.last), 32'(result.last));
				events_seen++;
				if (want.pressed)
					presses_seen++;
			end
			pop_hold = pick_gap();
		end
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d words still queued, %0d events due",
				$time, cycles, feed_q.size(), due_events.size());
			$display("tb_key_matrix_change_events: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus and end of run.
	// ---------------------------------------------------------------
	initial begin : stimulus
		int  useful;
		int  r;
		int  row;
		bit  mid_settle_done;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		errors = 0;
		cycles = 0;
		words_sent = 0;
		events_seen = 0;
		presses_seen = 0;
		starts_sent = 0;
		stops_sent = 0;
		ignored_sent = 0;
		hold_left = 0;
		pop_hold = 0;
		calm_left = 0;
		row_valid = '0;
		capture_on = 1'b0;
		for (int i = 0; i < ROWS; i++)
			seen_bits[i] = '0;
		for (int i = 0; i < 8; i++)
			gen_rows[i] = '0;

		// Directed part.
		// scan while idle, unused action, stop while idle: all ignored
		queue_word(ACT_SCAN, 0, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'hFF, 1'b0);
		queue_word(ACT_NONE, 7, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'hFF, 1'b0);
		queue_word(ACT_STOP, 0, 16'h0000, 32'h0, 5'd0, 8'h00, 1'b0);
		queue_word(ACT_START, 0, 16'h0000, 32'h0, 5'd0, 8'h00, 1'b0);
		// prime row 0, then every column presses, no change, every column releases
		queue_word(ACT_SCAN, 0, 16'h0000, 32'h0, 5'd0, 8'h00, 1'b0);
		queue_word(ACT_SCAN, 0, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'hFF, 1'b0);
		queue_word(ACT_SCAN, 0, 16'hFFFF, 32'h1234_5678, 5'd7, 8'h5A, 1'b0);
		queue_word(ACT_SCAN, 0, 16'h0000, 32'h0, 5'd0, 8'h00, 1'b0);
		// unused action while capturing
		queue_word(ACT_NONE, 0, 16'hFFFF, 32'hDEAD_BEEF, 5'd31, 8'hFF, 1'b0);
		// top row: full alternating flip, then lowest and highest column alone
		queue_word(ACT_SCAN, 7, 16'hA5A5, 32'h8000_0000, 5'd16, 8'h80, 1'b0);
		queue_word(ACT_SCAN, 7, 16'h5A5A, 32'h7FFF_FFFF, 5'd15, 8'h7F, 1'b0);
		queue_word(ACT_SCAN, 7, 16'h5A5B, 32'h0000_0001, 5'd1, 8'h01, 1'b0);
		queue_word(ACT_SCAN, 7, 16'hDA5B, 32'hFFFF_FFFE, 5'd30, 8'hFE, 1'b0);
		// start while capturing drops the valid marks
		queue_word(ACT_START, 7, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'hFF, 1'b0);
		queue_word(ACT_SCAN, 7, 16'h0001, 32'h0000_0100, 5'd2, 8'h10, 1'b0);
		queue_word(ACT_SCAN, 7, 16'h0000, 32'h0000_0200, 5'd3, 8'h20, 1'b0);
		// stop, scan ignored, restart
		queue_word(ACT_STOP, 7, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'hFF, 1'b0);
		queue_word(ACT_SCAN, 7, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 8'hFF, 1'b0);
		queue_word(ACT_START, 0, 16'h0000, 32'h0, 5'd0, 8'h00, 1'b0);
		queue_word(ACT_SCAN, 3, 16'h8001, 32'h0000_0400, 5'd4, 8'h04, 1'b0);
		queue_word(ACT_SCAN, 3, 16'h0180, 32'h0000_0800, 5'd8, 8'h08, 1'b0);
		// held back until everything above has drained
		queue_word(ACT_SCAN, 3, 16'h0180, 32'h0000_1000, 5'd9, 8'h09, 1'b1);
		starts_sent = 3;
		stops_sent = 2;
		ignored_sent = 5;
		gen_capture = 1'b1;
		gen_rows[0] = 16'h0000;
		gen_rows[3] = 16'h0180;
		gen_rows[7] = 16'h0000;

		// Random part: mostly scans while capturing, some commands and noise.
		useful = 0;
		mid_settle_done = 1'b0;
		while (useful < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			row = $urandom_range(0, 7);
			if (!gen_capture) begin
				if (r < 60) begin
					queue_random(ACT_START, row, 16'($urandom), 1'b0);
					gen_capture = 1'b1;
					starts_sent++;
					useful++;
				end else if (r < 80) begin
					queue_random(ACT_SCAN, row, 16'($urandom), 1'b0);
					ignored_sent++;
				end else if (r < 90) begin
					queue_random(ACT_NONE, row, 16'($urandom), 1'b0);
					ignored_sent++;
				end else begin
					queue_random(ACT_STOP, row, 16'($urandom), 1'b0);
					ignored_sent++;
				end
			end else if (r < 2) begin
				queue_random(ACT_START, row, 16'($urandom), 1'b0);
				starts_sent++;
				useful++;
			end else if (r < 4) begin
				queue_random(ACT_STOP, row, 16'($urandom), 1'b0);
				gen_capture = 1'b0;
				stops_sent++;
				useful++;
			end else if (r < 7) begin
				queue_random(ACT_NONE, row, 16'($urandom), 1'b0);
				ignored_sent++;
			end else begin
				gen_rows[row] = next_row(gen_rows[row]);
				// halfway through, one more full drain before a scan
				queue_random(ACT_SCAN, row, gen_rows[row],
					!mid_settle_done && useful >= RANDOM_WORDS / 2);
				if (useful >= RANDOM_WORDS / 2)
					mid_settle_done = 1'b1;
				useful++;
			end
		end

		// Hold reset, then release it on a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for all words to go in and all events to come out.
		do
			@(negedge clk);
		while (feed_q.size() != 0 || due_events.size() != 0);
		// Let any stray late event show up.
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d words: %0d starts, %0d stops, %0d ignored or idle scans",
			words_sent, starts_sent, stops_sent, ignored_sent);
		$display("checked %0d change events, %0d presses and %0d releases",
			events_seen, presses_seen, events_seen - presses_seen);
		if (errors == 0)
			$display("tb_key_matrix_change_events: clean");
		else
			$display("tb_key_matrix_change_events: errors");
		$finish;
	end

endmodule
